// ----- rtl/u16pe_pkg.sv -----
// Package for the UTF-16 URL percent encoder.
// Holds the pipeline payload types, character constants and the helper functions.
// It has no dependencies.
package u16pe_pkg;

	// ASCII codes used while building escapes.
	localparam logic [6:0] CH_PERCENT = 7'h25;
	localparam logic [6:0] CH_DIGIT0  = 7'h30;
	localparam logic [6:0] CH_UPPER_A = 7'h41;

	// Number of characters that one code unit can produce.
	localparam int MAX_CHARS = 9;
	localparam int CNT_W     = 4;

	// Payload carried by stage 1.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
		logic        safe;
	} cls_t;

	// Payload carried by stage 2: the UTF-8 bytes, with the first byte in slot 0.
	typedef struct packed {
		logic [2:0][7:0] utf8;
		logic [1:0]      nbytes;
		logic            safe;
		logic [6:0]      ch;
		logic            final_unit;
	} enc_t;

	// Returns 1 when the unit passes through unescaped.
	function automatic logic unit_is_safe(input logic [15:0] u);
		logic r;
		begin
			r = 1'b0;
			if (u[15:7] == '0) begin
				case (u[6:0]) inside
					[7'h30:7'h39], [7'h41:7'h5A], [7'h61:7'h7A]: r = 1'b1;
					7'h3A, 7'h2F, 7'h2E, 7'h3F, 7'h5F, 7'h2D, 7'h3D, 7'h26: r = 1'b1;
					default: r = 1'b0;
				endcase
			end
			return r;
		end
	endfunction

	// Upper-case hex digit for one nibble.
	function automatic logic [6:0] hex_char(input logic [3:0] n);
		logic [6:0] r;
		begin
			if (n < 4'd10) begin
				r = CH_DIGIT0 + {3'b000, n};
			end else begin
				r = CH_UPPER_A + {3'b000, n - 4'd10};
			end
			return r;
		end
	endfunction

endpackage

// ----- rtl/u16pe_classify.sv -----
// Stage 1 of the encoder: registers the code unit and tests it against the safe set.
// Units of value zero are dropped here. Depends on u16pe_pkg.
module u16pe_classify (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        code_unit,
	input  logic               final_unit,
	output logic               out_valid,
	input  logic               out_ready,
	output u16pe_pkg::cls_t    out_data
);
	import u16pe_pkg::*;

	logic valid_s1;
	cls_t data_s1;

	// The stage takes a new transaction whenever it is empty or is being drained.
	assign in_ready = !valid_s1 || out_ready;

	// Valid bit of the stage; a zero unit produces no output and leaves no item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && (code_unit != 16'h0000);
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.code_unit  <= code_unit;
			data_s1.final_unit <= final_unit;
			data_s1.safe       <= unit_is_safe(code_unit);
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/u16pe_utf8.sv -----
// Stage 2 of the encoder: converts each code unit to one to three UTF-8 bytes.
// Every surrogate half becomes the replacement character. Depends on u16pe_pkg.
module u16pe_utf8 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  u16pe_pkg::cls_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output u16pe_pkg::enc_t    out_data
);
	import u16pe_pkg::*;

	logic valid_s2;
	enc_t data_s2;
	enc_t enc_d;
	logic [15:0] u;

	assign in_ready = !valid_s2 || out_ready;
	assign u = in_data.code_unit;

	// UTF-8 byte builder.
	always_comb begin
		enc_d            = '0;
		enc_d.safe       = in_data.safe;
		enc_d.ch         = u[6:0];
		enc_d.final_unit = in_data.final_unit;
		if (u < 16'h0080) begin
			enc_d.nbytes  = 2'd1;
			enc_d.utf8[0] = {1'b0, u[6:0]};
		end else if (u < 16'h0800) begin
			enc_d.nbytes  = 2'd2;
			enc_d.utf8[0] = {3'b110, u[10:6]};
			enc_d.utf8[1] = {2'b10, u[5:0]};
		end else if (u[15:11] == 5'b11011) begin
			enc_d.nbytes  = 2'd3;
			enc_d.utf8[0] = 8'hEF;
			enc_d.utf8[1] = 8'hBF;
			enc_d.utf8[2] = 8'hBD;
		end else begin
			enc_d.nbytes  = 2'd3;
			enc_d.utf8[0] = {4'b1110, u[15:12]};
			enc_d.utf8[1] = {2'b10, u[11:6]};
			enc_d.utf8[2] = {2'b10, u[5:0]};
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= enc_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/u16pe_serializer.sv -----
// Stage 3 of the encoder: expands the bytes into escapes, a safe unit into one character,
// and shifts them out one character per cycle while out_ready is high. Depends on u16pe_pkg.
module u16pe_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  u16pe_pkg::enc_t    in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         out_char,
	output logic               unit_done,
	output logic               string_done
);
	import u16pe_pkg::*;

	logic                 valid_s3;
	logic [CNT_W-1:0]     count_s3;
	logic [6:0]           chars_s3 [MAX_CHARS];
	logic                 final_s3;
	logic [6:0]           chars_d  [MAX_CHARS];
	logic [CNT_W-1:0]     count_d;
	logic                 last_char;
	logic                 load;
	logic                 shift;

	assign last_char = (count_s3 == CNT_W'(1));
	assign in_ready  = !valid_s3 || (out_ready && last_char);
	assign load      = in_valid && in_ready;
	assign shift     = valid_s3 && out_ready && !last_char;

	// Character expansion: a safe unit is one character, else three per byte.
	always_comb begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			chars_d[i] = '0;
		end
		if (in_data.safe) begin
			chars_d[0] = in_data.ch;
			count_d    = CNT_W'(1);
		end else begin
			for (int k = 0; k < 3; k++) begin
				chars_d[3*k]   = CH_PERCENT;
				chars_d[3*k+1] = hex_char(in_data.utf8[k][7:4]);
				chars_d[3*k+2] = hex_char(in_data.utf8[k][3:0]);
			end
			count_d = CNT_W'(in_data.nbytes) * CNT_W'(3);
		end
	end

	// Control: valid bit and the count of characters still to send.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			count_s3 <= '0;
		end else if (load) begin
			valid_s3 <= 1'b1;
			count_s3 <= count_d;
		end else if (shift) begin
			count_s3 <= count_s3 - CNT_W'(1);
		end else if (valid_s3 && out_ready) begin
			valid_s3 <= 1'b0;
			count_s3 <= '0;
		end
	end

	// Character shift line; the head entry is always the next character.
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_CHARS; i++) begin
				chars_s3[i] <= chars_d[i];
			end
			final_s3 <= in_data.final_unit;
		end else if (shift) begin
			for (int i = 0; i < MAX_CHARS - 1; i++) begin
				chars_s3[i] <= chars_s3[i+1];
			end
			chars_s3[MAX_CHARS-1] <= '0;
		end
	end

	assign out_valid   = valid_s3;
	assign out_char    = chars_s3[0];
	assign unit_done   = last_char;
	assign string_done = last_char && final_s3;

endmodule

// ----- rtl/utf16_url_percent_encoder.sv -----
// Top level of the UTF-16 URL percent encoder: three pipeline stages in a row.
// Depends on u16pe_pkg, u16pe_classify, u16pe_utf8 and u16pe_serializer.
//
//   Channel  | Signals                      | Carries
//   ---------+------------------------------+------------------------------------------
//   s_axis   | tvalid tready tdata tlast    | one UTF-16 code unit, tlast = final_unit
//   m_axis   | tvalid tready tdata tuser    | one ASCII character, tuser = unit_done,
//            | tlast                        | tlast = string_done
//
// The first character of a code unit reaches m_axis once the unit has gone through the
// stage 1 and stage 2 registers and is loaded into stage 3. A unit gives one character
// when it is safe and three per UTF-8 byte otherwise (up to nine). The character shifter
// in the last stage sets the sustained rate of one character per cycle while m_axis_tready
// is high; a new unit loads in the same cycle that the last character of the previous one
// leaves. Reset clears the valid bits of all stages. While m_axis_tready is low every full
// stage holds its contents and s_axis_tready drops once the pipeline is full.
module utf16_url_percent_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero fill
	output logic [0:0]  m_axis_tuser,   // [0] unit_done
	output logic        m_axis_tlast
);
	import u16pe_pkg::*;

	logic       cls_valid;
	logic       cls_ready;
	cls_t       cls_data;
	logic       enc_valid;
	logic       enc_ready;
	enc_t       enc_data;
	logic [6:0] out_char;
	logic       unit_done;

	// Stage 1: safe-set test.
	u16pe_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.code_unit  (s_axis_tdata),
		.final_unit (s_axis_tlast),
		.out_valid  (cls_valid),
		.out_ready  (cls_ready),
		.out_data   (cls_data)
	);

	// Stage 2: UTF-8 conversion.
	u16pe_utf8 u_utf8 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cls_valid),
		.in_ready  (cls_ready),
		.in_data   (cls_data),
		.out_valid (enc_valid),
		.out_ready (enc_ready),
		.out_data  (enc_data)
	);

	// Stage 3: escape expansion and character output.
	u16pe_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (enc_valid),
		.in_ready    (enc_ready),
		.in_data     (enc_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_char    (out_char),
		.unit_done   (unit_done),
		.string_done (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};
	assign m_axis_tuser = unit_done;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf16_url_percent_encoder: random and directed code units
// go in on s_axis, and every character on m_axis is checked against a built-in predictor.
// It depends only on the RTL of the encoder.
module tb;

	localparam int LIMIT_CYCLES = 250000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_UNITS = 400;
	localparam int HOLD_START   = 150;
	localparam int HOLD_CYCLES  = 300;

	localparam logic [6:0] PERCENT_CHAR = 7'h25;

	typedef struct {
		logic [15:0] code_unit;
		logic        final_unit;
		int          gap_after;
	} unit_item_t;

	typedef struct {
		logic [6:0] ch;
		logic       unit_done;
		logic       string_done;
	} enc_char_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	unit_item_t pending_units[$];
	enc_char_t  expected_chars[$];
	unit_item_t next_unit;
	enc_char_t  want;

	string safe_chars =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ:/.?_-=&";

	int gap_left;
	int rx_wait;
	int rx_next_wait;
	int hold_left;
	bit hold_done;
	bit timed_out;
	int errors;
	int units_sent;
	int chars_checked;
	int strings_done;
	int input_stalls;
	int safe_units;
	int zero_units;
	int surrogate_units;
	int esc_units[1:3];

	utf16_url_percent_encoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// True for letters, digits and the punctuation that passes unescaped.
	function automatic bit is_url_safe(input logic [15:0] u);
		if (u >= 16'h30 && u <= 16'h39) return 1'b1;
		if (u >= 16'h41 && u <= 16'h5A) return 1'b1;
		if (u >= 16'h61 && u <= 16'h7A) return 1'b1;
		return u == 16'h3A || u == 16'h2F || u == 16'h2E || u == 16'h3F ||
			u == 16'h5F || u == 16'h2D || u == 16'h3D || u == 16'h26;
	endfunction

	function automatic logic [6:0] hex_upper(input logic [3:0] nib);
		if (nib < 4'd10) return 7'h30 + nib;
		return 7'h41 + (nib - 4'd10);
	endfunction

	function automatic void push_char(input logic [6:0] ch, input logic last_of_unit,
			input logic fin);
		enc_char_t c;
		c.ch          = ch;
		c.unit_done   = last_of_unit;
		c.string_done = last_of_unit & fin;
		expected_chars.push_back(c);
	endfunction

	// Predicts the characters that one accepted code unit produces.
	function automatic void encode_unit(input logic [15:0] u, input logic fin);
		logic [7:0] utf8 [3];
		int nbytes;
		if (u == 16'h0000) begin
			zero_units++;
			return;
		end
		if (is_url_safe(u)) begin
			safe_units++;
			push_char(u[6:0], 1'b1, fin);
			return;
		end
		if (u < 16'h0080) begin
			nbytes = 1;
			utf8[0] = u[7:0];
		end else if (u < 16'h0800) begin
			nbytes = 2;
			utf8[0] = {3'b110, u[10:6]};
			utf8[1] = {2'b10, u[5:0]};
		end else if (u >= 16'hD800 && u <= 16'hDFFF) begin
			// A surrogate half is never paired up; it becomes the replacement character.
			nbytes = 3;
			surrogate_units++;
			utf8[0] = 8'hEF;
			utf8[1] = 8'hBF;
			utf8[2] = 8'hBD;
		end else begin
			nbytes = 3;
			utf8[0] = {4'b1110, u[15:12]};
			utf8[1] = {2'b10, u[11:6]};
			utf8[2] = {2'b10, u[5:0]};
		end
		esc_units[nbytes]++;
		for (int i = 0; i < nbytes; i++) begin
			push_char(PERCENT_CHAR, 1'b0, fin);
			push_char(hex_upper(utf8[i][7:4]), 1'b0, fin);
			push_char(hex_upper(utf8[i][3:0]), i == nbytes - 1, fin);
		end
	endfunction

	// Draws a code unit, weighted toward the classes that exercise the escape paths.
	function automatic logic [15:0] random_unit();
		int kind;
		logic [15:0] u;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			u = {8'h00, safe_chars[$urandom_range(0, safe_chars.len() - 1)]};
		end else if (kind < 55) begin
			do u = 16'($urandom_range(1, 127)); while (is_url_safe(u));
		end else if (kind < 70) begin
			u = 16'($urandom_range(16'h0080, 16'h07FF));
		end else if (kind < 85) begin
			do u = 16'($urandom_range(16'h0800, 16'hFFFF));
			while (u >= 16'hD800 && u <= 16'hDFFF);
		end else if (kind < 93) begin
			u = 16'($urandom_range(16'hD800, 16'hDFFF));
		end else if (kind < 97) begin
			u = 16'($urandom);
		end else begin
			u = 16'h0000;
		end
		return u;
	endfunction

	function automatic void add_unit(input logic [15:0] u, input logic fin, input int gap);
		unit_item_t it;
		it.code_unit  = u;
		it.final_unit = fin;
		it.gap_after  = gap;
		pending_units.push_back(it);
	endfunction

	// Sender: presents queued code units and predicts each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			gap_left      <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				encode_unit(s_axis_tdata, s_axis_tlast);
				units_sent++;
			end
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left      <= gap_left - 1;
			end else if (pending_units.size() != 0) begin
				next_unit = pending_units.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_unit.code_unit;
				s_axis_tlast  <= next_unit.final_unit;
				gap_left      <= next_unit.gap_after;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end else begin
			input_stalls++;
		end
	end

	// One long receiver hold-off, so that the pipeline fills and back-pressures the input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && chars_checked >= HOLD_START) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: checks each character transaction and draws a stall after it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       <= 0;
		end else begin
			rx_next_wait = rx_wait;
			if (m_axis_tvalid && m_axis_tready) begin
				chars_checked++;
				if (m_axis_tlast) strings_done++;
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected character: expected none, %s",
						$time, "got");
					$display("%0t:   got data=%02h user=%b last=%b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== {1'b0, want.ch} ||
							m_axis_tuser[0] !== want.unit_done ||
							m_axis_tlast !== want.string_done) begin
						errors++;
						$display("%0t: character mismatch: expected data=%02h user=%b last=%b,",
							$time, {1'b0, want.ch}, want.unit_done, want.string_done);
						$display("%0t:   got data=%02h user=%b last=%b",
							$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
				// Part of every 200 characters is taken back to back.
				if ((chars_checked % 200) >= 100 && (chars_checked % 200) < 140)
					rx_next_wait = 0;
				else
					rx_next_wait = $urandom_range(0, 8);
			end
			if (hold_left != 0 || rx_next_wait != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait       <= (rx_next_wait != 0) ? rx_next_wait - 1 : 0;
			end else begin
				m_axis_tready <= 1'b1;
				rx_wait       <= 0;
			end
		end
	end

	initial begin
		int queued;
		int len;
		int cycles;
		bit quiet;
		bit open_string;

		// Directed part: safe-set extremes and punctuation, then each escape length.
		add_unit(16'h0061, 1'b0, $urandom_range(0, 8));
		add_unit(16'h007A, 1'b0, $urandom_range(0, 8));
		add_unit(16'h0041, 1'b0, $urandom_range(0, 8));
		add_unit(16'h005A, 1'b0, $urandom_range(0, 8));
		add_unit(16'h0030, 1'b0, $urandom_range(0, 8));
		add_unit(16'h0039, 1'b0, $urandom_range(0, 8));
		add_unit(16'h003A, 1'b0, 0);
		add_unit(16'h002F, 1'b0, 0);
		add_unit(16'h002E, 1'b0, 0);
		add_unit(16'h003F, 1'b0, 0);
		add_unit(16'h005F, 1'b0, 0);
		add_unit(16'h002D, 1'b0, 0);
		add_unit(16'h003D, 1'b0, 0);
		add_unit(16'h0026, 1'b1, $urandom_range(0, 8));
		// A zero unit with the final flag produces nothing at all.
		add_unit(16'h0000, 1'b1, $urandom_range(0, 8));
		add_unit(16'h0001, 1'b0, $urandom_range(0, 8));
		add_unit(16'h007F, 1'b0, $urandom_range(0, 8));
		add_unit(16'h0080, 1'b0, 0);
		add_unit(16'h07FF, 1'b1, 0);
		add_unit(16'h0800, 1'b0, $urandom_range(0, 8));
		// Surrogate pairs are not combined: each half gives its own replacement character.
		add_unit(16'hD83D, 1'b0, 0);
		add_unit(16'hDE00, 1'b0, 0);
		add_unit(16'hD800, 1'b0, $urandom_range(0, 8));
		add_unit(16'hDFFF, 1'b0, $urandom_range(0, 8));
		add_unit(16'hFFFF, 1'b1, $urandom_range(0, 8));

		// Random part: strings of 1 to 12 units ending in a final unit, some left open.
		queued = 0;
		while (queued < RANDOM_UNITS) begin
			len         = $urandom_range(1, 12);
			quiet       = ($urandom_range(0, 5) == 0);
			open_string = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++)
				add_unit(random_unit(), (i == len - 1) && !open_string,
					quiet ? 0 : $urandom_range(0, 8));
			queued += len;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cycles = 0;
		while (!(pending_units.size() == 0 && !s_axis_tvalid &&
				expected_chars.size() == 0) && cycles < LIMIT_CYCLES) begin
			@(negedge clk);
			cycles++;
		end
		if (cycles >= LIMIT_CYCLES) begin
			timed_out = 1'b1;
			$display("%0t: timeout after %0d cycles, %0d characters still expected",
				$time, cycles, expected_chars.size());
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (expected_chars.size() != 0) begin
				errors++;
				$display("%0t: %0d expected characters never arrived",
					$time, expected_chars.size());
			end
		end

		$display("Sent %0d code units: %0d safe, %0d/%0d/%0d escaped as 1/2/3 bytes,",
			units_sent, safe_units, esc_units[1], esc_units[2], esc_units[3]);
		$display("  %0d of them surrogates, and %0d zero units.", surrogate_units, zero_units);
		$display("Checked %0d characters and %0d string ends; input back-pressured %0d cycles.",
			chars_checked, strings_done, input_stalls);
		if (!timed_out && errors == 0)
			$display("utf16_url_percent_encoder test passed");
		else
			$display("utf16_url_percent_encoder test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/u16pe_pkg.sv
rtl/u16pe_classify.sv
rtl/u16pe_utf8.sv
rtl/u16pe_serializer.sv
rtl/utf16_url_percent_encoder.sv
tb/tb.sv
